// File: hdl/sorted_list_insert_delete_assert.svh
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_assert.svh
// Assertion macros used by the sorted list checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define SLI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared constants and types of the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

    // operation broadcast to every cell of the row
    typedef struct packed {
        logic                      ins_en;
        logic                      del_en;
        logic signed [VALUE_W-1:0] value;
    } sli_op_t;

endpackage

// File: hdl/sli_if.sv
// ----------------------------------------------------------------------------
// sli_if
// Valid/ready channels: command transactions in, result transactions out.
// ----------------------------------------------------------------------------
interface sli_cmd_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [sli_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface sli_res_if #(
    parameter int COUNT_W = $clog2(sli_pkg::DEPTH_DEFAULT + 1)
);
    logic                                valid;
    logic                                ready;
    logic [sli_pkg::STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]                  entry_count;
    logic signed [sli_pkg::VALUE_W-1:0]  smallest;
    logic signed [sli_pkg::VALUE_W-1:0]  largest;

    modport source (output valid, output status, output entry_count,
                    output smallest, output largest, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input smallest, input largest, output ready);
endinterface

// File: hdl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell
// One position of the sorted row: holds a value, compares it with the
// broadcast operand and takes its new value from itself or a neighbor.
// ----------------------------------------------------------------------------
module sli_cell #(
    parameter int COUNT_W = 5,
    parameter int IDX     = 0
) (
    input  logic                               clk,
    input  sli_pkg::sli_op_t                   op,
    input  logic [COUNT_W-1:0]                 count,
    input  logic                               left_go,
    input  logic signed [sli_pkg::VALUE_W-1:0] left_value,
    input  logic signed [sli_pkg::VALUE_W-1:0] right_value,
    output logic                               go,
    output logic                               hit,
    output logic signed [sli_pkg::VALUE_W-1:0] value,
    output logic signed [sli_pkg::VALUE_W-1:0] tail
);

    localparam logic [COUNT_W-1:0] POS      = COUNT_W'(IDX);
    localparam logic [COUNT_W-1:0] POS_NEXT = COUNT_W'(IDX + 1);

    logic signed [sli_pkg::VALUE_W-1:0] value_reg;
    logic signed [sli_pkg::VALUE_W-1:0] value_next;
    logic                               occupied;
    logic                               shift_dn;

    assign occupied = POS < count;
    // insert lands at or left of here
    assign go       = !occupied || (value_reg > op.value);
    // delete point at or left of here
    assign shift_dn = !occupied || (value_reg >= op.value);
    assign hit      = occupied && (value_reg == op.value);
    assign tail     = (POS_NEXT == count) ? value_reg : '0;
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (op.ins_en && go)
        begin
            value_next = left_go ? left_value : op.value;
        end
        else if (op.del_en && shift_dn)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: hdl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Sorted multiset of signed 32-bit values with insert and delete commands.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH signed values in ascending order in a row of
// cells. An insert places the value after any equal values already held; a
// delete removes the first entry equal to the value. Every command
// transaction yields one result transaction: status (ok, full with the insert
// dropped, or not found), the count after the command, and the smallest and
// largest values held (both 0 when empty). All cells compare against the
// command value at once and shift by one position in the cycle the command is
// accepted, so one command is taken per clock while the pending stage can
// take it; its result is formed from the updated row when it leaves that
// stage and waits in an output register. A pending result stage between the
// row and the output register lets a new command enter while a result is
// still waiting to be taken. Result valid rises once the result has moved
// into the output register. Storage holds no reset: only positions below the
// count are ever used, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
    parameter int DEPTH   = sli_pkg::DEPTH_DEFAULT,
    parameter int COUNT_W = $clog2(DEPTH + 1)
) (
    input  logic      clk,
    input  logic      rst_n,
    sli_cmd_if.sink   request,
    sli_res_if.source response
);

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    // row wiring
    sli_pkg::sli_op_t                   op;
    logic [DEPTH-1:0]                   go;
    logic [DEPTH-1:0]                   hit;
    logic signed [sli_pkg::VALUE_W-1:0] cell_value [DEPTH];
    logic signed [sli_pkg::VALUE_W-1:0] cell_tail  [DEPTH];
    logic signed [sli_pkg::VALUE_W-1:0] tail_value;

    logic accept;
    logic found;
    logic full;
    logic out_load;

    logic [COUNT_W-1:0]            count_reg;
    logic [COUNT_W-1:0]            count_next;
    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    logic [sli_pkg::STATUS_W-1:0]  pend_status_reg;
    logic [sli_pkg::STATUS_W-1:0]  pend_status_next;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [sli_pkg::STATUS_W-1:0]       out_status_reg;
    logic [COUNT_W-1:0]                 out_count_reg;
    logic signed [sli_pkg::VALUE_W-1:0] out_smallest_reg;
    logic signed [sli_pkg::VALUE_W-1:0] out_largest_reg;

    // the pending result moves to the output when the output is free
    assign out_load      = pend_valid_reg && (!out_valid_reg || response.ready);
    // a new command may enter whenever the pending slot empties this cycle
    assign request.ready = !pend_valid_reg || out_load;
    assign accept        = request.valid && request.ready;

    assign full  = count_reg == COUNT_FULL;
    assign found = |hit;

    assign op.value  = request.value;
    assign op.ins_en = accept && (request.command == sli_pkg::CMD_INSERT) && !full;
    assign op.del_en = accept && (request.command == sli_pkg::CMD_DELETE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                               left_go;
            logic signed [sli_pkg::VALUE_W-1:0] left_value;
            logic signed [sli_pkg::VALUE_W-1:0] right_value;

            if (gi == 0)
            begin : g_head
                assign left_go    = 1'b0;
                assign left_value = cell_value[gi];
            end
            else
            begin : g_body
                assign left_go    = go[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                // beyond the last slot: content past the new count is unused
                assign right_value = cell_value[gi];
            end
            else
            begin : g_mid
                assign right_value = cell_value[gi+1];
            end

            sli_cell #(
                .COUNT_W (COUNT_W),
                .IDX     (gi)
            ) u_cell (
                .clk         (clk),
                .op          (op),
                .count       (count_reg),
                .left_go     (left_go),
                .left_value  (left_value),
                .right_value (right_value),
                .go          (go[gi]),
                .hit         (hit[gi]),
                .value       (cell_value[gi]),
                .tail        (cell_tail[gi])
            );
        end
    endgenerate

    // at most one cell flags itself as the tail; the rest give zero
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.ins_en)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (op.del_en)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_comb
    begin
        pend_status_next = pend_status_reg;
        pend_valid_next  = pend_valid_reg && !out_load;
        if (accept)
        begin
            pend_valid_next = 1'b1;
            if (request.command == sli_pkg::CMD_INSERT)
            begin
                pend_status_next = full ? sli_pkg::STATUS_FULL : sli_pkg::STATUS_OK;
            end
            else
            begin
                pend_status_next = found ? sli_pkg::STATUS_OK : sli_pkg::STATUS_MISSING;
            end
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && !response.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // pending status and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        if (out_load)
        begin
            // row and count still show the pending command's outcome here
            out_status_reg   <= pend_status_reg;
            out_count_reg    <= count_reg;
            out_smallest_reg <= (count_reg != '0) ? cell_value[0] : '0;
            out_largest_reg  <= tail_value;
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_status_reg;
    assign response.entry_count = out_count_reg;
    assign response.smallest    = out_smallest_reg;
    assign response.largest     = out_largest_reg;

endmodule

// File: hdl/sli_checker.sv
// ----------------------------------------------------------------------------
// sli_checker
// Port-level checks of the sorted list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_assert.svh"

module sli_checker #(
    parameter int DEPTH   = sli_pkg::DEPTH_DEFAULT,
    parameter int COUNT_W = $clog2(DEPTH + 1)
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic [sli_pkg::STATUS_W-1:0]       res_status,
    input logic [COUNT_W-1:0]                 res_count,
    input logic signed [sli_pkg::VALUE_W-1:0] res_smallest,
    input logic signed [sli_pkg::VALUE_W-1:0] res_largest
);

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    `SLI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_count) && $stable(res_smallest) && $stable(res_largest), "result changed while stalled")
    `SLI_ASSERT_NOW(a_empty_zero, res_valid && (res_count == '0), (res_smallest == '0) && (res_largest == '0), "empty store must report zero bounds")
    `SLI_ASSERT_NOW(a_bounds_order, res_valid && (res_count != '0), res_smallest <= res_largest, "smallest above largest")
    `SLI_ASSERT_NOW(a_full_count, res_valid && (res_status == sli_pkg::STATUS_FULL), res_count == COUNT_FULL, "full status with store not full")

endmodule

bind sorted_list_insert_delete sli_checker #(
    .DEPTH   (DEPTH),
    .COUNT_W (COUNT_W)
) u_sli_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (response.valid),
    .res_ready    (response.ready),
    .res_status   (response.status),
    .res_count    (response.entry_count),
    .res_smallest (response.smallest),
    .res_largest  (response.largest)
);
